>>> hdl/fbrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrb_pkg
// Shared constants and types for the rectangle blend/fill framebuffer.
// ----------------------------------------------------------------------------
package fbrb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  localparam int CFG_W  = 9;
  localparam int CIDX_W = 1;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 16;
  localparam int SIZE_W = 12;
  localparam int PIX_W  = 32;
  localparam int CLIP_W = POS_W + 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 9'd256;

  localparam logic [PIX_W-1:0] RB_MASK = 32'h00ff_00ff;
  localparam logic [PIX_W-1:0] G_MASK  = 32'h0000_ff00;
  localparam logic [8:0]       ALPHA_ONE = 9'h100;

  typedef enum logic [2:0] {
    ST_CLEAR_MEM,
    ST_IDLE,
    ST_SETUP,
    ST_PAINT,
    ST_DRAIN,
    ST_RD_ISSUE,
    ST_RD_RESP
  } state_t;

endpackage

>>> hdl/fbrb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrb_in_if
// Command request channel: valid/ready plus command payload.
// ----------------------------------------------------------------------------
interface fbrb_in_if import fbrb_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [SIZE_W-1:0]        rect_width;
  logic [SIZE_W-1:0]        rect_height;
  logic [PIX_W-1:0]         fill_color;

  modport source (
    output valid, command, pos_x, pos_y, rect_width, rect_height, fill_color,
    input  ready
  );
  modport sink (
    input  valid, command, pos_x, pos_y, rect_width, rect_height, fill_color,
    output ready
  );
endinterface

>>> hdl/fbrb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrb_out_if
// Pixel read result channel: valid/ready plus pixel payload.
// ----------------------------------------------------------------------------
interface fbrb_out_if import fbrb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_value;
  logic              in_frame;

  modport source (output valid, pixel_value, in_frame, input ready);
  modport sink   (input  valid, pixel_value, in_frame, output ready);
endinterface

>>> hdl/framebuffer_rect_blend_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_rect_blend_fill
// 32-bit ARGB framebuffer with clear, blended fill and pixel read commands.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    command, pos_x, pos_y, rect_width,
//                                rect_height, fill_color
//   out_ch   out  valid/ready    pixel_value, in_frame
//   cfg_*    in   cfg_we only    cfg_index, cfg_wdata
//
// Clear and fill paint the clipped area one pixel per cycle (fill through the
//   read / blend / write-back pipe; the memory has separate read and write ports).
// Read: setup, memory read (skipped when outside the frame), then the output
//   register; empty rectangles are taken without leaving idle.
// After reset a clearing pass writes zero to all DEPTH words before the
//   first request is taken.
// A pending result stalls only a following read, not clears or fills.
// ----------------------------------------------------------------------------
module framebuffer_rect_blend_fill import fbrb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  fbrb_in_if.sink           in_ch,
  fbrb_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]  frame_width_r;
  logic [CFG_W-1:0]  frame_height_r;
  logic [CFG_W-1:0]  fw;
  logic [CFG_W-1:0]  fh;

  logic [CMD_W-1:0]  cmd_r;
  logic [PIX_W-1:0]  color_r;
  logic              in_frame_r;
  logic [CFG_W-1:0]  lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic [CFG_W-1:0]  px_r, py_r;
  logic [ADDR_W-1:0] row_base_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic              p1_v_r, p2_v_r;
  logic [ADDR_W-1:0] p1_addr_r, p2_addr_r;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pixel_r;
  logic              out_in_frame_r;

  logic [PIX_W-1:0]  frame_mem [DEPTH];
  logic [PIX_W-1:0]  rdata_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [PIX_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] cur_addr;
  logic [PIX_W-1:0]  blend_pix;

  logic signed [CLIP_W-1:0] x_s, y_s, xe_s, ye_s, fw_s, fh_s;
  logic signed [CLIP_W-1:0] lo_x_s, lo_y_s, hi_x_s, hi_y_s;
  logic              rect_live, pt_inside, accept, is_fill;
  logic              last_col, last_row, out_free;
  logic [2*CFG_W-1:0] base_prod;

  // effective frame size
  assign fw = (32'(frame_width_r) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : frame_width_r;
  assign fh = (32'(frame_height_r) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : frame_height_r;

  // clipping
  assign x_s    = CLIP_W'(in_ch.pos_x);
  assign y_s    = CLIP_W'(in_ch.pos_y);
  assign xe_s   = x_s + signed'(CLIP_W'(in_ch.rect_width));
  assign ye_s   = y_s + signed'(CLIP_W'(in_ch.rect_height));
  assign fw_s   = signed'(CLIP_W'(fw));
  assign fh_s   = signed'(CLIP_W'(fh));
  assign lo_x_s = x_s[CLIP_W-1] ? '0 : x_s;
  assign lo_y_s = y_s[CLIP_W-1] ? '0 : y_s;
  assign hi_x_s = (xe_s < fw_s) ? xe_s : fw_s;
  assign hi_y_s = (ye_s < fh_s) ? ye_s : fh_s;
  assign rect_live = (lo_x_s < hi_x_s) && (lo_y_s < hi_y_s);
  assign pt_inside = !x_s[CLIP_W-1] && (x_s < fw_s) && !y_s[CLIP_W-1] && (y_s < fh_s);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_fill     = (cmd_r == CMD_FILL);
  assign cur_addr    = row_base_r + ADDR_W'(px_r);
  assign last_col    = (px_r + CFG_W'(1)) == hi_x_r;
  assign last_row    = (py_r + CFG_W'(1)) == hi_y_r;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign base_prod   = {{CFG_W{1'b0}}, lo_y_r} * {{CFG_W{1'b0}}, fw};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR_MEM;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mem_re    = 1'b0;
    case (state_r)
      ST_CLEAR_MEM: begin
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.command == CMD_READ) begin
            state_nxt = ST_SETUP;
          end else if ((in_ch.command == CMD_CLEAR || in_ch.command == CMD_FILL)
                       && rect_live) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        if (cmd_r == CMD_READ) begin
          state_nxt = in_frame_r ? ST_RD_ISSUE : ST_RD_RESP;
        end else begin
          state_nxt = ST_PAINT;
        end
      end
      ST_PAINT: begin
        mem_re = is_fill;
        if (last_col && last_row) state_nxt = is_fill ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r) state_nxt = ST_IDLE;
      end
      ST_RD_ISSUE: begin
        mem_re    = 1'b1;
        state_nxt = ST_RD_RESP;
      end
      ST_RD_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = color_r;
    if (state_r == ST_CLEAR_MEM) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (p2_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = p2_addr_r;
      mem_wdata = blend_pix;
    end else if (state_r == ST_PAINT && !is_fill) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= frame_mem[cur_addr];
  end

  fbrb_blend u_blend (
    .clk    (clk),
    .bottom (rdata_r),
    .top    (color_r),
    .result (blend_pix)
  );

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control counters and pipe valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR_MEM) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      p1_v_r <= (state_r == ST_PAINT) && is_fill;
      p2_v_r <= p1_v_r;
      if (state_r == ST_RD_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p1_addr_r <= cur_addr;
    p2_addr_r <= p1_addr_r;
    if (accept) begin
      cmd_r      <= in_ch.command;
      color_r    <= in_ch.fill_color;
      in_frame_r <= pt_inside;
      if (in_ch.command == CMD_READ) begin
        lo_x_r <= x_s[CFG_W-1:0];
        lo_y_r <= y_s[CFG_W-1:0];
      end else begin
        lo_x_r <= lo_x_s[CFG_W-1:0];
        lo_y_r <= lo_y_s[CFG_W-1:0];
      end
      hi_x_r <= hi_x_s[CFG_W-1:0];
      hi_y_r <= hi_y_s[CFG_W-1:0];
    end
    if (state_r == ST_SETUP) begin
      row_base_r <= ADDR_W'(base_prod);
      px_r       <= lo_x_r;
      py_r       <= lo_y_r;
    end else if (state_r == ST_PAINT) begin
      if (last_col) begin
        px_r       <= lo_x_r;
        py_r       <= py_r + CFG_W'(1);
        row_base_r <= row_base_r + ADDR_W'(fw);
      end else begin
        px_r <= px_r + CFG_W'(1);
      end
    end
    if (state_r == ST_RD_RESP && out_free) begin
      out_pixel_r    <= in_frame_r ? rdata_r : '0;
      out_in_frame_r <= in_frame_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_value = out_pixel_r;
  assign out_ch.in_frame    = out_in_frame_r;

`ifndef SYNTHESIS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!p1_v_r && !p2_v_r))
    else $error("request taken while write-back pending");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    p2_v_r |-> $past(p1_v_r))
    else $error("write-back without prior read");

  a_paint_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAINT) |-> ((px_r < hi_x_r) && (py_r < hi_y_r)))
    else $error("paint cursor outside clipped rectangle");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RD_RESP))
    else $error("result raised outside read response");
`endif

endmodule

>>> hdl/fbrb_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrb_blend
// Alpha blend of a source colour over a stored pixel, one register stage
// after the multipliers; result is valid in the cycle after the inputs.
// ----------------------------------------------------------------------------
module fbrb_blend import fbrb_pkg::*; (
  input  logic             clk,
  input  logic [PIX_W-1:0] bottom,
  input  logic [PIX_W-1:0] top,
  output logic [PIX_W-1:0] result
);

  logic [7:0]       ta;
  logic [7:0]       ba;
  logic [PIX_W-1:0] rb_b;
  logic [PIX_W-1:0] g_b;
  logic [PIX_W-1:0] rb_diff;
  logic [PIX_W-1:0] g_diff;

  logic [7:0]       ta_r;
  logic [16:0]      a_prod_r;
  logic [PIX_W-1:0] rb_b_r;
  logic [PIX_W-1:0] g_b_r;
  logic [PIX_W-1:0] rb_prod_r;
  logic [PIX_W-1:0] g_prod_r;

  logic [7:0]       a_sum;
  logic [PIX_W-1:0] rb_sum;
  logic [PIX_W-1:0] g_sum;

  assign ta      = top[31:24];
  assign ba      = bottom[31:24];
  assign rb_b    = bottom & RB_MASK;
  assign g_b     = bottom & G_MASK;
  assign rb_diff = (top & RB_MASK) - rb_b;
  assign g_diff  = (top & G_MASK) - g_b;

  always_ff @(posedge clk) begin
    ta_r      <= ta;
    a_prod_r  <= {9'd0, ba} * {8'd0, (ALPHA_ONE - {1'b0, ta})};
    rb_b_r    <= rb_b;
    g_b_r     <= g_b;
    rb_prod_r <= rb_diff * {24'd0, ta};
    g_prod_r  <= g_diff * {24'd0, ta};
  end

  assign a_sum  = ta_r + a_prod_r[15:8];
  assign rb_sum = rb_b_r + {8'd0, rb_prod_r[31:8]};
  assign g_sum  = g_b_r + {8'd0, g_prod_r[31:8]};
  assign result = {a_sum, rb_sum[23:16], g_sum[15:8], rb_sum[7:0]};

endmodule
